@@ hdl/itfn_pkg.sv @@
// ----------------------------------------------------------------------------
// itfn_pkg
// shared types and constants for the indexed triangle face normal expander
// ----------------------------------------------------------------------------
package itfn_pkg;

    localparam int VERTEX_SLOTS = 256;
    localparam int SLOT_W       = $clog2(VERTEX_SLOTS);
    localparam int FIFO_DEPTH   = 2;
    localparam int PTR_W        = $clog2(FIFO_DEPTH);
    localparam int CNT_W        = $clog2(FIFO_DEPTH + 1);

    // normalizer datapath width, covers S * 2^28 plus the cross term
    localparam int NW    = 100;
    localparam int SQ_W  = 67;
    localparam int SUM_W = 68;
    localparam int MAG_W = 34;
    localparam int N_W   = 35;
    localparam int Q_W   = 15;
    localparam int Q_MSB = 14;

    typedef enum logic [0:0]
    {
        KIND_LOAD = 1'b0,
        KIND_TRI  = 1'b1
    } item_kind_t;

    typedef struct packed
    {
        item_kind_t         kind;
        logic [SLOT_W-1:0]  slot;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [SLOT_W-1:0]  ia;
        logic [SLOT_W-1:0]  ib;
        logic [SLOT_W-1:0]  ic;
        logic               fin;
    } item_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_CAP_C,
        ST_DIFF,
        ST_CROSS,
        ST_SQUARE,
        ST_NORM_GO,
        ST_NORM_WAIT,
        ST_EMIT
    } back_state_t;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [7:0] v);
        return SLOT_W'(32'(v) % VERTEX_SLOTS);
    endfunction

endpackage

@@ hdl/itfn_front.sv @@
// ----------------------------------------------------------------------------
// itfn_front
// input register stage: accepts items, decodes kind and folds indices
// ----------------------------------------------------------------------------
module itfn_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  logic [7:0]          vertex_slot,
    input  logic signed [15:0]  load_x,
    input  logic signed [15:0]  load_y,
    input  logic signed [15:0]  load_z,
    input  logic [7:0]          corner_index_a,
    input  logic [7:0]          corner_index_b,
    input  logic [7:0]          corner_index_c,
    input  logic                final_triangle,
    output logic                push,
    output itfn_pkg::item_t     push_item,
    input  logic                full
);

    logic             vld_reg;
    itfn_pkg::item_t  item_reg;
    itfn_pkg::item_t  item_next;
    logic             take;

    assign push     = vld_reg && !full;
    assign in_stall = vld_reg && full;
    assign take     = in_valid && !in_stall;
    assign push_item = item_reg;

    always_comb
    begin
        item_next.kind = itfn_pkg::item_kind_t'(kind);
        item_next.slot = itfn_pkg::slot_of(vertex_slot);
        item_next.x    = load_x;
        item_next.y    = load_y;
        item_next.z    = load_z;
        item_next.ia   = itfn_pkg::slot_of(corner_index_a);
        item_next.ib   = itfn_pkg::slot_of(corner_index_b);
        item_next.ic   = itfn_pkg::slot_of(corner_index_c);
        item_next.fin  = final_triangle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (take)
        begin
            vld_reg <= 1'b1;
        end
        else if (push)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

@@ hdl/itfn_fifo.sv @@
// ----------------------------------------------------------------------------
// itfn_fifo
// short first-word-fall-through queue between front and back
// ----------------------------------------------------------------------------
module itfn_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  itfn_pkg::item_t  push_item,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output itfn_pkg::item_t  head_item
);

    itfn_pkg::item_t                 store [itfn_pkg::FIFO_DEPTH];
    logic [itfn_pkg::PTR_W-1:0]      wr_ptr_reg;
    logic [itfn_pkg::PTR_W-1:0]      rd_ptr_reg;
    logic [itfn_pkg::CNT_W-1:0]      count_reg;
    logic                            do_push;
    logic                            do_pop;

    assign full       = (count_reg == itfn_pkg::CNT_W'(itfn_pkg::FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = store[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hdl/itfn_norm.sv @@
// ----------------------------------------------------------------------------
// itfn_norm
// bitwise search for the largest q with q^2 * s <= c^2 * 2^28
// ----------------------------------------------------------------------------
module itfn_norm
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [itfn_pkg::SQ_W-1:0]    c_sq,
    input  logic [itfn_pkg::SUM_W-1:0]   s,
    output logic                         done,
    output logic [itfn_pkg::Q_W-1:0]     q
);

    logic                         active_reg;
    logic                         done_reg;
    logic [3:0]                   bit_reg;
    logic [itfn_pkg::Q_W-1:0]     q_reg;
    // p = q^2 s, u = q s 2^(b+1), v = s 2^(2b)
    logic [itfn_pkg::NW-1:0]      p_reg;
    logic [itfn_pkg::NW-1:0]      u_reg;
    logic [itfn_pkg::NW-1:0]      v_reg;
    logic [itfn_pkg::NW-1:0]      rhs_reg;
    logic [itfn_pkg::NW-1:0]      trial;
    logic [itfn_pkg::NW-1:0]      u_acc;
    logic                         fits;

    assign trial = p_reg + u_reg + v_reg;
    assign fits  = (trial <= rhs_reg);
    assign u_acc = fits ? (u_reg + (v_reg << 1)) : u_reg;
    assign done  = done_reg;
    assign q     = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            bit_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                bit_reg    <= 4'(itfn_pkg::Q_MSB);
            end
            else if (active_reg)
            begin
                bit_reg <= bit_reg - 1'b1;
                if (bit_reg == '0)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rhs_reg <= itfn_pkg::NW'(c_sq) << 28;
            v_reg   <= itfn_pkg::NW'(s) << 28;
            u_reg   <= '0;
            p_reg   <= '0;
            q_reg   <= '0;
        end
        else if (active_reg)
        begin
            if (fits)
            begin
                p_reg          <= trial;
                q_reg[bit_reg] <= 1'b1;
            end
            u_reg <= u_acc >> 1;
            v_reg <= v_reg >> 2;
        end
    end

endmodule

@@ hdl/itfn_back.sv @@
// ----------------------------------------------------------------------------
// itfn_back
// vertex table, cross product, normalize sequencing and corner emission
// ----------------------------------------------------------------------------
module itfn_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  itfn_pkg::item_t     head_item,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  position_x,
    output logic signed [15:0]  position_y,
    output logic signed [15:0]  position_z,
    output logic signed [15:0]  normal_x,
    output logic signed [15:0]  normal_y,
    output logic signed [15:0]  normal_z,
    output logic                degenerate,
    output logic                corner_last,
    output logic                mesh_end
);

    itfn_pkg::back_state_t state_reg;
    itfn_pkg::back_state_t state_next;

    logic [47:0]                  table_mem [itfn_pkg::VERTEX_SLOTS];
    logic [47:0]                  rd_data_reg;
    logic [itfn_pkg::SLOT_W-1:0]  rd_addr;
    logic                         mem_we;

    logic [itfn_pkg::SLOT_W-1:0]  ia_reg;
    logic [itfn_pkg::SLOT_W-1:0]  ib_reg;
    logic [itfn_pkg::SLOT_W-1:0]  ic_reg;
    logic                         fin_reg;
    logic [47:0]                  pos_reg [3];
    logic signed [16:0]           ab_reg [3];
    logic signed [16:0]           ac_reg [3];
    logic signed [itfn_pkg::N_W-1:0]   n_reg [3];
    logic [itfn_pkg::SQ_W-1:0]    sq_reg [3];
    logic [itfn_pkg::SUM_W-1:0]   s_reg;
    logic                         degen_reg;
    logic [15:0]                  nout_reg [3];
    logic [1:0]                   k_reg;

    logic                         step;
    logic                         emit_load;
    logic                         norm_start;
    logic                         norm_done;
    logic [itfn_pkg::Q_W-1:0]     norm_q;

    logic signed [16:0]           m1a;
    logic signed [16:0]           m1b;
    logic signed [16:0]           m2a;
    logic signed [16:0]           m2b;
    logic signed [33:0]           prod1;
    logic signed [33:0]           prod2;
    logic [itfn_pkg::MAG_W-1:0]   mag;
    logic [itfn_pkg::SUM_W-1:0]   sq_full;
    logic [itfn_pkg::SUM_W-1:0]   s_sum;
    logic [15:0]                  q_ext;

    logic                         out_valid_reg;
    logic [47:0]                  out_pos_reg;
    logic [15:0]                  out_n_reg [3];
    logic                         out_degen_reg;
    logic                         out_last_reg;
    logic                         out_end_reg;

    itfn_norm u_norm
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .c_sq  (sq_reg[k_reg]),
        .s     (s_reg),
        .done  (norm_done),
        .q     (norm_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            itfn_pkg::ST_IDLE:
            begin
                if (head_valid && head_item.kind == itfn_pkg::KIND_TRI)
                begin
                    state_next = itfn_pkg::ST_RD_A;
                end
            end
            itfn_pkg::ST_RD_A:   state_next = itfn_pkg::ST_RD_B;
            itfn_pkg::ST_RD_B:   state_next = itfn_pkg::ST_RD_C;
            itfn_pkg::ST_RD_C:   state_next = itfn_pkg::ST_CAP_C;
            itfn_pkg::ST_CAP_C:  state_next = itfn_pkg::ST_DIFF;
            itfn_pkg::ST_DIFF:   state_next = itfn_pkg::ST_CROSS;
            itfn_pkg::ST_CROSS:
            begin
                if (k_reg == 2'd2)
                begin
                    state_next = itfn_pkg::ST_SQUARE;
                end
            end
            itfn_pkg::ST_SQUARE:
            begin
                if (k_reg == 2'd2)
                begin
                    state_next = itfn_pkg::ST_NORM_GO;
                end
            end
            itfn_pkg::ST_NORM_GO: state_next = itfn_pkg::ST_NORM_WAIT;
            itfn_pkg::ST_NORM_WAIT:
            begin
                if (norm_done)
                begin
                    state_next = (k_reg == 2'd2) ? itfn_pkg::ST_EMIT
                                                 : itfn_pkg::ST_NORM_GO;
                end
            end
            itfn_pkg::ST_EMIT:
            begin
                if (emit_load && k_reg == 2'd2)
                begin
                    state_next = itfn_pkg::ST_IDLE;
                end
            end
            default: state_next = itfn_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        pop        = 1'b0;
        mem_we     = 1'b0;
        rd_addr    = ia_reg;
        norm_start = 1'b0;
        emit_load  = 1'b0;
        step       = 1'b0;
        unique case (state_reg)
            itfn_pkg::ST_IDLE:
            begin
                pop    = head_valid;
                mem_we = head_valid && head_item.kind == itfn_pkg::KIND_LOAD;
            end
            itfn_pkg::ST_RD_A:   rd_addr = ia_reg;
            itfn_pkg::ST_RD_B:   rd_addr = ib_reg;
            itfn_pkg::ST_RD_C:   rd_addr = ic_reg;
            itfn_pkg::ST_CROSS:  step = 1'b1;
            itfn_pkg::ST_SQUARE: step = 1'b1;
            itfn_pkg::ST_NORM_GO: norm_start = 1'b1;
            itfn_pkg::ST_NORM_WAIT: step = norm_done;
            itfn_pkg::ST_EMIT:
            begin
                emit_load = !out_valid_reg || !out_stall;
                step      = emit_load;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= itfn_pkg::ST_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (step)
            begin
                k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
            end
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // vertex table, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[head_item.slot] <= {head_item.x, head_item.y, head_item.z};
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    // cross product operands for component k
    always_comb
    begin
        unique case (k_reg)
            2'd0:
            begin
                m1a = ab_reg[1]; m1b = ac_reg[2]; m2a = ab_reg[2]; m2b = ac_reg[1];
            end
            2'd1:
            begin
                m1a = ab_reg[2]; m1b = ac_reg[0]; m2a = ab_reg[0]; m2b = ac_reg[2];
            end
            default:
            begin
                m1a = ab_reg[0]; m1b = ac_reg[1]; m2a = ab_reg[1]; m2b = ac_reg[0];
            end
        endcase
    end

    assign prod1   = m1a * m1b;
    assign prod2   = m2a * m2b;
    assign mag     = n_reg[k_reg][itfn_pkg::N_W-1]
                     ? itfn_pkg::MAG_W'(-n_reg[k_reg])
                     : itfn_pkg::MAG_W'(n_reg[k_reg]);
    assign sq_full = mag * mag;
    assign s_sum   = ((k_reg == 2'd0) ? '0 : s_reg) + sq_full;
    assign q_ext   = 16'(norm_q);

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            itfn_pkg::ST_IDLE:
            begin
                ia_reg  <= head_item.ia;
                ib_reg  <= head_item.ib;
                ic_reg  <= head_item.ic;
                fin_reg <= head_item.fin;
            end
            itfn_pkg::ST_RD_B:  pos_reg[0] <= rd_data_reg;
            itfn_pkg::ST_RD_C:  pos_reg[1] <= rd_data_reg;
            itfn_pkg::ST_CAP_C: pos_reg[2] <= rd_data_reg;
            itfn_pkg::ST_DIFF:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ab_reg[i] <= 17'($signed(pos_reg[1][47-16*i -: 16]))
                               - 17'($signed(pos_reg[0][47-16*i -: 16]));
                    ac_reg[i] <= 17'($signed(pos_reg[2][47-16*i -: 16]))
                               - 17'($signed(pos_reg[0][47-16*i -: 16]));
                end
            end
            itfn_pkg::ST_CROSS:
            begin
                n_reg[k_reg] <= itfn_pkg::N_W'(prod1) - itfn_pkg::N_W'(prod2);
            end
            itfn_pkg::ST_SQUARE:
            begin
                sq_reg[k_reg] <= sq_full[itfn_pkg::SQ_W-1:0];
                s_reg         <= s_sum;
                if (k_reg == 2'd2)
                begin
                    degen_reg <= (s_sum == '0);
                end
            end
            itfn_pkg::ST_NORM_WAIT:
            begin
                if (norm_done)
                begin
                    if (degen_reg)
                    begin
                        nout_reg[k_reg] <= '0;
                    end
                    else
                    begin
                        nout_reg[k_reg] <= n_reg[k_reg][itfn_pkg::N_W-1] ? -q_ext : q_ext;
                    end
                end
            end
            default:
            begin
                degen_reg <= degen_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_pos_reg   <= pos_reg[k_reg];
            out_n_reg[0]  <= nout_reg[0];
            out_n_reg[1]  <= nout_reg[1];
            out_n_reg[2]  <= nout_reg[2];
            out_degen_reg <= degen_reg;
            out_last_reg  <= (k_reg == 2'd2);
            out_end_reg   <= (k_reg == 2'd2) && fin_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign position_x  = out_pos_reg[47:32];
    assign position_y  = out_pos_reg[31:16];
    assign position_z  = out_pos_reg[15:0];
    assign normal_x    = out_n_reg[0];
    assign normal_y    = out_n_reg[1];
    assign normal_z    = out_n_reg[2];
    assign degenerate  = out_degen_reg;
    assign corner_last = out_last_reg;
    assign mesh_end    = out_end_reg;

endmodule

@@ hdl/indexed_triangle_face_normal_expander.sv @@
// a triangle's corners follow the front register, the queue and the back-end read,
//   difference, cross, square, normalize and emit states; each triangle is bound by
//   the 15-step normalize search run once per normal component, plus three corner transactions
// items pop only while idle, in order; load items go straight to the vertex table
// reset: asynchronous active-low rst_n clears the queue, sequencer and valids;
//   the vertex table is not cleared and holds garbage until written
// ----------------------------------------------------------------------------
// indexed_triangle_face_normal_expander
// vertex table loads and per-triangle unit face normal, expanded to corners
// ----------------------------------------------------------------------------
module indexed_triangle_face_normal_expander
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  logic [7:0]          vertex_slot,
    input  logic signed [15:0]  load_x,
    input  logic signed [15:0]  load_y,
    input  logic signed [15:0]  load_z,
    input  logic [7:0]          corner_index_a,
    input  logic [7:0]          corner_index_b,
    input  logic [7:0]          corner_index_c,
    input  logic                final_triangle,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  position_x,
    output logic signed [15:0]  position_y,
    output logic signed [15:0]  position_z,
    output logic signed [15:0]  normal_x,
    output logic signed [15:0]  normal_y,
    output logic signed [15:0]  normal_z,
    output logic                degenerate,
    output logic                corner_last,
    output logic                mesh_end
);

    logic             push;
    itfn_pkg::item_t  push_item;
    logic             full;
    logic             pop;
    logic             head_valid;
    itfn_pkg::item_t  head_item;

    itfn_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .vertex_slot    (vertex_slot),
        .load_x         (load_x),
        .load_y         (load_y),
        .load_z         (load_z),
        .corner_index_a (corner_index_a),
        .corner_index_b (corner_index_b),
        .corner_index_c (corner_index_c),
        .final_triangle (final_triangle),
        .push           (push),
        .push_item      (push_item),
        .full           (full)
    );

    itfn_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    itfn_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_item   (head_item),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .position_x  (position_x),
        .position_y  (position_y),
        .position_z  (position_z),
        .normal_x    (normal_x),
        .normal_y    (normal_y),
        .normal_z    (normal_z),
        .degenerate  (degenerate),
        .corner_last (corner_last),
        .mesh_end    (mesh_end)
    );

endmodule

@@ hdl/itfn_checker.sv @@
// ----------------------------------------------------------------------------
// itfn_checker
// port-level checks on the expander output stream
// ----------------------------------------------------------------------------
module itfn_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic signed [15:0]  position_x,
    input  logic signed [15:0]  normal_x,
    input  logic signed [15:0]  normal_y,
    input  logic signed [15:0]  normal_z,
    input  logic                degenerate,
    input  logic                corner_last,
    input  logic                mesh_end
);

    // mesh end only rides on the closing corner
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mesh_end |-> corner_last)
        else $error("mesh_end without corner_last");

    // degenerate faces carry a zero normal
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> normal_x == 16'sd0 && normal_y == 16'sd0
                                    && normal_z == 16'sd0)
        else $error("degenerate face with nonzero normal");

    // a real face never has an all-zero unit normal
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !degenerate |-> normal_x != 16'sd0 || normal_y != 16'sd0
                                     || normal_z != 16'sd0)
        else $error("zero normal on a non-degenerate face");

    // stalled output transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(normal_x)
                                   && $stable(position_x) && $stable(corner_last))
        else $error("output changed while stalled");

endmodule

bind indexed_triangle_face_normal_expander itfn_checker u_itfn_checker (.*);

@@ tb/indexed_triangle_face_normal_expander_test.sv @@
// ----------------------------------------------------------------------------
// indexed_triangle_face_normal_expander_test
// loads vertex positions and sends triangles with random handshake gaps, then
// checks every corner against a local predictor of the position and the normal
// ----------------------------------------------------------------------------
module indexed_triangle_face_normal_expander_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct
    {
        logic signed [15:0] px, py, pz;
        logic signed [15:0] nx, ny, nz;
        logic               degen;
        logic               last;
        logic               mend;
    } corner_t;

    typedef struct
    {
        itfn_pkg::item_kind_t k;
        logic [7:0]         slot;
        logic signed [15:0] x, y, z;
        logic [7:0]         a, b, c;
        logic               fin;
        logic               known;
        logic signed [15:0] enx, eny, enz;
        logic               edeg;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic kind = 1'b0;
    logic [7:0] vertex_slot = '0;
    logic signed [15:0] load_x = '0, load_y = '0, load_z = '0;
    logic [7:0] corner_index_a = '0, corner_index_b = '0, corner_index_c = '0;
    logic final_triangle = 1'b0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic signed [15:0] position_x, position_y, position_z;
    logic signed [15:0] normal_x, normal_y, normal_z;
    logic degenerate, corner_last, mesh_end;

    indexed_triangle_face_normal_expander dut (.*);

    always #1 clk = ~clk;

    logic signed [15:0] vtx_x [itfn_pkg::VERTEX_SLOTS];
    logic signed [15:0] vtx_y [itfn_pkg::VERTEX_SLOTS];
    logic signed [15:0] vtx_z [itfn_pkg::VERTEX_SLOTS];
    bit                 vtx_written [itfn_pkg::VERTEX_SLOTS];
    corner_t            corners_due [$];
    row_t               directed [$];

    int  mismatches = 0;
    int  corners_seen = 0;
    int  triangles_sent = 0;
    int  loads_sent = 0;
    int  cycles = 0;
    bit  hold_off = 1'b0;
    localparam int CYCLE_LIMIT = 400000;

    // largest q with q^2 * s <= c^2 * 2^28
    function automatic logic [15:0] unit_component(input logic signed [34:0] n,
                                                   input logic [67:0] s);
        logic [99:0]  rhs;
        logic [99:0]  lhs;
        logic [34:0]  mag;
        logic [14:0]  q;
        logic [14:0]  t;
        mag = n < 0 ? -n : n;
        rhs = (100'(mag) * 100'(mag)) << 28;
        q = '0;
        for (int bitpos = 14; bitpos >= 0; bitpos--)
        begin
            t = q | (15'd1 << bitpos);
            lhs = 100'(s) * 100'(t) * 100'(t);
            if (lhs <= rhs)
                q = t;
        end
        return n < 0 ? -16'(q) : 16'(q);
    endfunction

    function automatic void predict_triangle(input logic [7:0] a, b, c, input logic fin,
                                             output logic signed [15:0] nx, ny, nz,
                                             output logic deg);
        logic signed [17:0] ab [3];
        logic signed [17:0] ac [3];
        logic signed [34:0] n [3];
        logic [67:0] s;
        int ix [3];
        corner_t cr;
        ix[0] = itfn_pkg::slot_of(a);
        ix[1] = itfn_pkg::slot_of(b);
        ix[2] = itfn_pkg::slot_of(c);
        ab[0] = 18'(vtx_x[ix[1]]) - 18'(vtx_x[ix[0]]);
        ab[1] = 18'(vtx_y[ix[1]]) - 18'(vtx_y[ix[0]]);
        ab[2] = 18'(vtx_z[ix[1]]) - 18'(vtx_z[ix[0]]);
        ac[0] = 18'(vtx_x[ix[2]]) - 18'(vtx_x[ix[0]]);
        ac[1] = 18'(vtx_y[ix[2]]) - 18'(vtx_y[ix[0]]);
        ac[2] = 18'(vtx_z[ix[2]]) - 18'(vtx_z[ix[0]]);
        n[0] = 35'(ab[1]) * 35'(ac[2]) - 35'(ab[2]) * 35'(ac[1]);
        n[1] = 35'(ab[2]) * 35'(ac[0]) - 35'(ab[0]) * 35'(ac[2]);
        n[2] = 35'(ab[0]) * 35'(ac[1]) - 35'(ab[1]) * 35'(ac[0]);
        s = 68'(70'(n[0]) * 70'(n[0])) + 68'(70'(n[1]) * 70'(n[1]))
            + 68'(70'(n[2]) * 70'(n[2]));
        deg = (s == 0);
        nx = deg ? 16'sd0 : unit_component(n[0], s);
        ny = deg ? 16'sd0 : unit_component(n[1], s);
        nz = deg ? 16'sd0 : unit_component(n[2], s);
        for (int j = 0; j < 3; j++)
        begin
            cr.px = vtx_x[ix[j]]; cr.py = vtx_y[ix[j]]; cr.pz = vtx_z[ix[j]];
            cr.nx = nx; cr.ny = ny; cr.nz = nz;
            cr.degen = deg;
            cr.last = (j == 2);
            cr.mend = (j == 2) ? fin : 1'b0;
            corners_due.push_back(cr);
        end
    endfunction

    task automatic send_item(input row_t r);
        logic signed [15:0] nx, ny, nz;
        logic deg;
        kind <= r.k;
        vertex_slot <= r.slot;
        load_x <= r.x; load_y <= r.y; load_z <= r.z;
        corner_index_a <= r.a; corner_index_b <= r.b; corner_index_c <= r.c;
        final_triangle <= r.fin;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (r.k == itfn_pkg::KIND_LOAD)
        begin
            vtx_x[itfn_pkg::slot_of(r.slot)] = r.x;
            vtx_y[itfn_pkg::slot_of(r.slot)] = r.y;
            vtx_z[itfn_pkg::slot_of(r.slot)] = r.z;
            vtx_written[itfn_pkg::slot_of(r.slot)] = 1'b1;
            loads_sent++;
        end
        else
        begin
            predict_triangle(r.a, r.b, r.c, r.fin, nx, ny, nz, deg);
            triangles_sent++;
            if (r.known && (nx !== r.enx || ny !== r.eny || nz !== r.enz || deg !== r.edeg))
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row normal %0d %0d %0d deg %0b, predictor %0d %0d %0d %0b",
                             r.enx, r.eny, r.enz, r.edeg, nx, ny, nz, deg);
            end
        end
    endtask

    task automatic idle_sender();
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic row_t load_row(input logic [7:0] s, input logic signed [15:0] x, y, z);
        row_t r;
        r = '{itfn_pkg::KIND_LOAD, s, x, y, z, 8'($urandom), 8'($urandom), 8'($urandom),
              1'($urandom), 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0};
        return r;
    endfunction

    function automatic row_t tri_row(input logic [7:0] a, b, c, input logic fin);
        row_t r;
        r = '{itfn_pkg::KIND_TRI, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              a, b, c, fin, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0};
        return r;
    endfunction

    function automatic row_t known_tri(input logic [7:0] a, b, c, input logic fin,
                                       input logic signed [15:0] nx, ny, nz,
                                       input logic deg);
        row_t r;
        r = tri_row(a, b, c, fin);
        r.known = 1'b1;
        r.enx = nx; r.eny = ny; r.enz = nz; r.edeg = deg;
        return r;
    endfunction

    function automatic logic [7:0] written_slot();
        int s;
        do s = $urandom_range(0, 255); while (!vtx_written[s]);
        return 8'(s);
    endfunction

    // receiver: random stalls, plus a long hold-off when asked
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            out_stall <= (gap > 0) || hold_off;
            if (hold_off)
            begin
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            else
                repeat (gap > 0 ? gap : 1) @(posedge clk);
            if (gap > 0 && !hold_off)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    // corner checker
    always @(posedge clk)
    begin
        corner_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            corners_seen++;
            if (corners_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected corner transaction pos %0d %0d %0d",
                             position_x, position_y, position_z);
            end
            else
            begin
                e = corners_due.pop_front();
                if (position_x !== e.px || position_y !== e.py || position_z !== e.pz
                    || normal_x !== e.nx || normal_y !== e.ny || normal_z !== e.nz
                    || degenerate !== e.degen || corner_last !== e.last
                    || mesh_end !== e.mend)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"corner mismatch exp p %0d %0d %0d n %0d %0d %0d d%0b l%0b m%0b",
                                  " got p %0d %0d %0d n %0d %0d %0d d%0b l%0b m%0b"},
                                 e.px, e.py, e.pz, e.nx, e.ny, e.nz, e.degen, e.last, e.mend,
                                 position_x, position_y, position_z, normal_x, normal_y,
                                 normal_z, degenerate, corner_last, mesh_end);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        row_t r;
        int sent;
        logic [7:0] s;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // axis-aligned triangles give exact unit normals
        directed.push_back(load_row(8'd0, 16'sd0, 16'sd0, 16'sd0));
        directed.push_back(load_row(8'd1, 16'sd256, 16'sd0, 16'sd0));
        directed.push_back(load_row(8'd2, 16'sd0, 16'sd256, 16'sd0));
        directed.push_back(load_row(8'd255, 16'sh7fff, 16'sh7fff, 16'sh7fff));
        directed.push_back(load_row(8'd254, -16'sh8000, -16'sh8000, -16'sh8000));
        directed.push_back(load_row(8'd3, 16'sh7fff, -16'sh8000, 16'sh7fff));
        directed.push_back(load_row(8'd4, -16'sh8000, 16'sh7fff, -16'sh8000));
        directed.push_back(load_row(8'd5, 16'sd0, 16'sd0, 16'sd256));
        directed.push_back(known_tri(8'd0, 8'd1, 8'd2, 1'b0, 16'sd0, 16'sd0, 16'sd16384, 1'b0));
        directed.push_back(known_tri(8'd0, 8'd2, 8'd1, 1'b1, 16'sd0, 16'sd0, -16'sd16384, 1'b0));
        directed.push_back(known_tri(8'd0, 8'd2, 8'd5, 1'b0, 16'sd16384, 16'sd0, 16'sd0, 1'b0));
        directed.push_back(known_tri(8'd0, 8'd5, 8'd1, 1'b0, 16'sd0, 16'sd16384, 16'sd0, 1'b0));
        // repeated corner and collinear corners: degenerate
        directed.push_back(known_tri(8'd1, 8'd1, 8'd2, 1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b1));
        directed.push_back(known_tri(8'd7, 8'd7, 8'd7, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b1));
        directed.push_back(known_tri(8'd255, 8'd0, 8'd254, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b1));
        // full-scale coordinates stress the wide arithmetic
        directed.push_back(tri_row(8'd255, 8'd3, 8'd4, 1'b1));
        directed.push_back(tri_row(8'd254, 8'd3, 8'd255, 1'b0));
        directed.push_back(tri_row(8'd4, 8'd255, 8'd3, 1'b1));
        directed.push_back(load_row(8'd128, -16'sd1, 16'sd1, -16'sd1));
        directed.push_back(tri_row(8'd128, 8'd0, 8'd1, 1'b0));
        directed.push_back(tri_row(8'd5, 8'd128, 8'd254, 1'b1));

        // slot 7 is read above, so write it first
        r = load_row(8'd7, 16'sd3, -16'sd9, 16'sd100);
        send_item(r);
        foreach (directed[i])
        begin
            send_item(directed[i]);
            idle_sender();
        end

        // write one random slot per group of eight; random triangles draw only written slots
        for (int i = 0; i < 256; i += 8)
        begin
            r = load_row(8'(i + $urandom_range(0, 7)), 16'($urandom), 16'($urandom),
                         16'($urandom));
            send_item(r);
        end
        for (int i = 0; i < 256; i++)
            if (!vtx_written[i])
            begin
                vtx_written[i] = 1'b0;
            end

        sent = 0;
        while (sent < 126)
        begin
            if (sent == 60)
            begin
                // long receiver hold-off while the sender keeps offering items
                hold_off = 1'b1;
            end
            if (sent == 120)
            begin
                // sender pause until the corner queue drains
                in_valid <= 1'b0;
                while (corners_due.size() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 2) == 0)
            begin
                s = 8'($urandom);
                if ($urandom_range(0, 7) == 0)
                    r = load_row(s, $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000,
                                 16'($urandom), $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000);
                else if ($urandom_range(0, 3) == 0)
                    r = load_row(s, 16'($signed(10'($urandom))), 16'($signed(10'($urandom))),
                                 16'($signed(10'($urandom))));
                else
                    r = load_row(s, 16'($urandom), 16'($urandom), 16'($urandom));
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                s = written_slot();
                r = tri_row(s, $urandom_range(0, 1) ? s : written_slot(), written_slot(),
                            1'($urandom));
            end
            else
                r = tri_row(written_slot(), written_slot(), written_slot(), 1'($urandom));
            send_item(r);
            sent++;
            if (sent >= 60 && sent < 75)
                continue;
            idle_sender();
        end
        in_valid <= 1'b0;

        while (corners_due.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("sent %0d loads and %0d triangles, checked %0d corners",
                 loads_sent, triangles_sent, corners_seen);
        if (mismatches == 0)
            $display("SUCCESS");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
